>>> design/elevator_car_sweep_controller_assert.svh
// Assertion macros used by the checker.
`ifndef ELEVATOR_CAR_SWEEP_CONTROLLER_ASSERT_SVH
`define ELEVATOR_CAR_SWEEP_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define ECS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ECS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg
// Types, codes and sizes shared by the car sweep controller.
// ----------------------------------------------------------------------------
package ecs_pkg;

    localparam int SLOTS   = 16;
    localparam int FLOORS  = 64;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FLOOR_W = 6;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_CAR  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MO_STOP = 2'd0,
        MO_UP   = 2'd1,
        MO_DOWN = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIR  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_phase             phase;
        logic [FLOOR_W-1:0] call;
        logic [FLOOR_W-1:0] target;
    } t_slot;

    typedef struct packed {
        logic [FLOOR_W-1:0] lo_c;
        logic [FLOOR_W-1:0] hi_c;
        logic [FLOOR_W-1:0] lo_t;
        logic [FLOOR_W-1:0] hi_t;
        logic               any;
        logic               got_on;
        logic [CNT_W-1:0]   n_off;
        logic [CNT_W-1:0]   n_on;
    } t_scan_stats;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> design/ecs_slot_ram.sv
// ----------------------------------------------------------------------------
// ecs_slot_ram
// Request table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ecs_slot_ram
    import ecs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_slot             i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_slot             o_rdata
);

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ecs_scan.sv
// ----------------------------------------------------------------------------
// ecs_scan
// One pass over the table: read each slot, serve the floor when i_serve
// is set, write back, and gather min/max of call and target floors.
// ----------------------------------------------------------------------------
module ecs_scan
    import ecs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic               i_go,
    input  logic               i_serve,
    input  logic [FLOOR_W-1:0] i_floor,
    input  logic [SLOTS-1:0]   i_used,
    input  t_slot              i_rdata,
    output logic [SLOT_W-1:0]  o_raddr,
    output logic               o_we,
    output logic [SLOT_W-1:0]  o_waddr,
    output t_slot              o_wdata,
    output logic               o_done,
    output t_scan_stats        o_stats
);

    logic              r_run;
    logic [SLOT_W:0]   r_idx;
    logic              r_pv;
    logic [SLOT_W-1:0] r_paddr;
    t_scan_stats       r_stats;
    t_scan_stats       n_stats;
    logic              used;
    logic              alight;
    logic              board;

    assign o_raddr = r_idx[SLOT_W-1:0];
    assign used    = i_used[r_paddr];
    assign alight  = used && i_serve && (i_rdata.phase == PH_CAR)
                     && (i_rdata.target == i_floor);
    assign board   = used && i_serve && (i_rdata.phase == PH_WAIT)
                     && (i_rdata.call == i_floor);

    assign o_we    = r_pv && (alight || board);
    assign o_waddr = r_paddr;
    always_comb begin
        o_wdata       = i_rdata;
        o_wdata.phase = alight ? PH_DONE : PH_CAR;
    end

    assign o_done  = r_pv && (r_paddr == SLOT_W'(SLOTS - 1));
    assign o_stats = r_stats;

    always_comb begin
        n_stats = r_stats;
        if (r_pv && used) begin
            n_stats.any = 1'b1;
            if (i_rdata.call < r_stats.lo_c)   n_stats.lo_c = i_rdata.call;
            if (i_rdata.call > r_stats.hi_c)   n_stats.hi_c = i_rdata.call;
            if (i_rdata.target < r_stats.lo_t) n_stats.lo_t = i_rdata.target;
            if (i_rdata.target > r_stats.hi_t) n_stats.hi_t = i_rdata.target;
        end
        if (r_pv && alight) begin
            n_stats.n_off = sat_inc(r_stats.n_off);
        end
        if (r_pv && board) begin
            n_stats.n_on   = sat_inc(r_stats.n_on);
            n_stats.got_on = 1'b1;
        end
        if (i_go) begin
            n_stats.lo_c   = '1;
            n_stats.hi_c   = '0;
            n_stats.lo_t   = '1;
            n_stats.hi_t   = '0;
            n_stats.any    = 1'b0;
            n_stats.got_on = 1'b0;
        end
        if (i_clr) begin
            n_stats.n_off = '0;
            n_stats.n_on  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pv    <= 1'b0;
            r_idx   <= '0;
            r_paddr <= '0;
            r_stats <= '0;
        end else begin
            r_stats <= n_stats;
            if (i_go) begin
                r_run <= 1'b1;
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (r_run && (r_idx < (SLOT_W + 1)'(SLOTS))) begin
                r_pv    <= 1'b1;
                r_paddr <= r_idx[SLOT_W-1:0];
                r_idx   <= r_idx + (SLOT_W + 1)'(1);
            end else begin
                r_run <= 1'b0;
                r_pv  <= 1'b0;
            end
        end
    end

endmodule

>>> design/elevator_car_sweep_controller.sv
// ----------------------------------------------------------------------------
// elevator_car_sweep_controller
// Sweep controller for one car serving a table of ride requests.
// ----------------------------------------------------------------------------
// An item (tick or add request) is taken when start is high and busy low.
// Its result appears for one cycle with o_valid; the receiver cannot stall
// it. A rejected add, an add while a run is in progress or a tick while
// stopped goes from the transfer straight to the done state and then to
// the result strobe. Other items run one to three passes over the request
// table memory, one slot read-modify-written per cycle, with sequencer
// steps in between and the done state before the result. The next item
// can be taken in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module elevator_car_sweep_controller
    import ecs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [FLOOR_W-1:0] i_call_floor,
    input  logic [FLOOR_W-1:0] i_target_floor,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [FLOOR_W-1:0] o_car_floor,
    output logic [FLOOR_W-1:0] o_goal_floor,
    output logic [1:0]         o_motion,
    output logic               o_on_return_leg,
    output logic               o_run_active,
    output logic               o_door_cycled,
    output logic [CNT_W-1:0]   o_alighted,
    output logic [CNT_W-1:0]   o_boarded
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_ENDSW, S_DONE} t_state;
    typedef enum logic [1:0] {M_MINMAX, M_START, M_TICK, M_FINAL} t_mode;

    t_state             r_state;
    t_mode              r_mode;
    logic [SLOTS-1:0]   r_used;
    logic [FLOOR_W-1:0] r_floor;
    logic [FLOOR_W-1:0] r_goal;
    t_motion            r_heading;
    logic               r_ret;
    logic               r_running;
    t_status            r_status;
    logic               r_go;
    logic               r_strobe;

    logic               accept;
    logic               add_we;
    logic [SLOT_W-1:0]  free_slot;
    logic               have_free;
    logic [FLOOR_W-1:0] call_c;
    logic [FLOOR_W-1:0] target_c;
    t_motion            want;
    t_slot              add_slot;

    t_slot              rdata;
    logic [SLOT_W-1:0]  raddr;
    logic               scan_we;
    logic [SLOT_W-1:0]  scan_waddr;
    t_slot              scan_wdata;
    logic               scan_done;
    t_scan_stats        st;

    logic [FLOOR_W-1:0] g_calls;
    logic [FLOOR_W-1:0] g_tgts;
    logic [FLOOR_W-1:0] g_tick;
    logic [FLOOR_W-1:0] g_end;

    function automatic logic [FLOOR_W-1:0] upd_goal(
        input logic [FLOOR_W-1:0] lo,
        input logic [FLOOR_W-1:0] hi,
        input logic               any,
        input logic [FLOOR_W-1:0] fl,
        input logic [FLOOR_W-1:0] gl
    );
        if (!any)                      return gl;
        else if (fl == hi && gl == lo) return fl;
        else                           return (fl < hi) ? hi : lo;
    endfunction

    function automatic logic [FLOOR_W-1:0] clamp(input logic [FLOOR_W-1:0] f);
        return (int'(f) > FLOORS - 1) ? FLOOR_W'(FLOORS - 1) : f;
    endfunction

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign call_c   = clamp(i_call_floor);
    assign target_c = clamp(i_target_floor);
    assign want     = (target_c > call_c) ? MO_UP : MO_DOWN;

    always_comb begin
        free_slot = '0;
        have_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
                have_free = 1'b1;
            end
        end
    end

    assign add_we = accept && i_req_type && !(r_running && r_heading != want) && have_free;
    always_comb begin
        add_slot.phase  = PH_WAIT;
        add_slot.call   = call_c;
        add_slot.target = target_c;
    end

    ecs_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (add_we || scan_we),
        .i_waddr (add_we ? free_slot : scan_waddr),
        .i_wdata (add_we ? add_slot : scan_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ecs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (accept),
        .i_go    (r_go),
        .i_serve (r_mode != M_MINMAX),
        .i_floor (r_floor),
        .i_used  (r_used),
        .i_rdata (rdata),
        .o_raddr (raddr),
        .o_we    (scan_we),
        .o_waddr (scan_waddr),
        .o_wdata (scan_wdata),
        .o_done  (scan_done),
        .o_stats (st)
    );

    assign g_calls = upd_goal(st.lo_c, st.hi_c, st.any, r_floor, r_goal);
    assign g_tgts  = upd_goal(st.lo_t, st.hi_t, st.any, r_floor, r_goal);
    assign g_tick  = st.got_on ? (r_ret ? g_tgts : g_calls) : r_goal;
    assign g_end   = g_tgts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_MINMAX;
            r_used    <= '0;
            r_floor   <= '0;
            r_goal    <= '0;
            r_heading <= MO_STOP;
            r_ret     <= 1'b0;
            r_running <= 1'b0;
            r_status  <= ST_OK;
            r_go      <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                        if (i_req_type) begin
                            if (r_running && r_heading != want) begin
                                r_status <= ST_DIR;
                            end else if (!have_free) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_used[free_slot] <= 1'b1;
                                if (!r_running) begin
                                    r_running <= 1'b1;
                                    r_ret     <= 1'b0;
                                    r_goal    <= call_c;
                                    r_mode    <= M_MINMAX;
                                    r_go      <= 1'b1;
                                    r_state   <= S_SCAN;
                                end
                            end
                        end else if (r_running && r_heading != MO_STOP) begin
                            if (r_heading == MO_UP && r_floor < r_goal) begin
                                r_floor <= r_floor + FLOOR_W'(1);
                            end else if (r_heading == MO_DOWN && r_floor > r_goal) begin
                                r_floor <= r_floor - FLOOR_W'(1);
                            end
                            r_mode  <= M_TICK;
                            r_go    <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    unique case (r_mode)
                        M_MINMAX: begin
                            r_goal <= g_calls;
                            if (r_floor == g_calls) begin
                                r_mode  <= M_START;
                                r_go    <= 1'b1;
                                r_state <= S_SCAN;
                            end else begin
                                r_heading <= (r_floor < g_calls) ? MO_UP : MO_DOWN;
                                r_state   <= S_DONE;
                            end
                        end
                        M_START: begin
                            if (st.got_on) begin
                                r_goal <= g_calls;
                            end
                            r_state <= S_ENDSW;
                        end
                        M_TICK: begin
                            r_goal <= g_tick;
                            if ((r_heading == MO_UP && r_floor >= g_tick) ||
                                (r_heading == MO_DOWN && r_floor <= g_tick)) begin
                                r_state <= S_ENDSW;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        M_FINAL: begin
                            if (st.got_on) begin
                                r_goal <= g_tgts;
                            end
                            r_used    <= '0;
                            r_heading <= MO_STOP;
                            r_ret     <= 1'b0;
                            r_running <= 1'b0;
                            r_state   <= S_DONE;
                        end
                    endcase
                end
                S_ENDSW: begin
                    if (r_ret) begin
                        r_used    <= '0;
                        r_heading <= MO_STOP;
                        r_ret     <= 1'b0;
                        r_running <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_ret  <= 1'b1;
                        r_goal <= g_end;
                        if (r_floor == g_end) begin
                            r_mode  <= M_FINAL;
                            r_go    <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_heading <= (r_floor < g_end) ? MO_UP : MO_DOWN;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_strobe;
    assign o_status        = r_status;
    assign o_car_floor     = r_floor;
    assign o_goal_floor    = r_goal;
    assign o_motion        = r_heading;
    assign o_on_return_leg = r_ret;
    assign o_run_active    = r_running;
    assign o_alighted      = st.n_off;
    assign o_boarded       = st.n_on;
    assign o_door_cycled   = (st.n_off != '0) || (st.n_on != '0);

endmodule

>>> design/ecs_checker.sv
// ----------------------------------------------------------------------------
// ecs_checker
// Port-level checks of the car sweep controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "elevator_car_sweep_controller_assert.svh"

module ecs_checker
    import ecs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [1:0]         o_status,
    input logic [1:0]         o_motion,
    input logic               o_run_active,
    input logic               o_door_cycled,
    input logic [CNT_W-1:0]   o_alighted,
    input logic [CNT_W-1:0]   o_boarded
);

    `ECS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ECS_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `ECS_ASSERT_IMP(a_stop_idle, i_clk, i_rst_n, o_valid && !o_run_active,
                    o_motion == MO_STOP)
    `ECS_ASSERT_IMP(a_reject_quiet, i_clk, i_rst_n, o_valid && o_status != ST_OK,
                    !o_door_cycled && o_alighted == '0 && o_boarded == '0)

endmodule

bind elevator_car_sweep_controller ecs_checker u_ecs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_motion      (o_motion),
    .o_run_active  (o_run_active),
    .o_door_cycled (o_door_cycled),
    .o_alighted    (o_alighted),
    .o_boarded     (o_boarded)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the car sweep controller.
// ----------------------------------------------------------------------------
// A queue of ride requests and ticks is built up front. It holds a directed
// opening, then random runs that are mostly direction-matched adds between
// ticks. A clocked driver issues the items with random gaps. An item-level
// software model of the car predicts every result, and a clocked monitor
// compares each result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ecs_pkg::*;

    localparam int RAND_ITEMS = 1150;
    localparam int CYC_LIMIT  = 400000;

    typedef struct {
        bit                 is_add;
        logic [FLOOR_W-1:0] call;
        logic [FLOOR_W-1:0] target;
        int                 gap;
        bit                 drain;
    } t_item;

    typedef struct {
        t_status            status;
        logic [FLOOR_W-1:0] car_floor;
        logic [FLOOR_W-1:0] goal_floor;
        t_motion            motion;
        logic               ret_leg;
        logic               run;
        logic               door;
        logic [CNT_W-1:0]   off_cnt;
        logic [CNT_W-1:0]   on_cnt;
    } t_trip;

    typedef struct {
        bit          used [SLOTS];
        t_phase      ph   [SLOTS];
        int unsigned cl   [SLOTS];
        int unsigned tg   [SLOTS];
        int unsigned flr;
        int unsigned gl;
        t_motion     hd;
        bit          ret_leg;
        bit          run;
        int unsigned n_off;
        int unsigned n_on;
        bit          door;
    } t_car;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic [FLOOR_W-1:0] i_call_floor;
    logic [FLOOR_W-1:0] i_target_floor;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [FLOOR_W-1:0] o_car_floor;
    logic [FLOOR_W-1:0] o_goal_floor;
    logic [1:0]         o_motion;
    logic               o_on_return_leg;
    logic               o_run_active;
    logic               o_door_cycled;
    logic [CNT_W-1:0]   o_alighted;
    logic [CNT_W-1:0]   o_boarded;

    t_item pending_q [$];
    t_trip trip_q [$];
    t_car  plan_car;
    t_car  live_car;
    int    wait_cnt;
    int    n_total;
    int    n_sent;
    int    n_checked;
    int    n_bad;
    int    n_ticks;
    int    n_adds;
    int    n_dir_rej;
    int    n_full_rej;
    int    n_runs;
    int    cycles;

    elevator_car_sweep_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_call_floor    (i_call_floor),
        .i_target_floor  (i_target_floor),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_car_floor     (o_car_floor),
        .o_goal_floor    (o_goal_floor),
        .o_motion        (o_motion),
        .o_on_return_leg (o_on_return_leg),
        .o_run_active    (o_run_active),
        .o_door_cycled   (o_door_cycled),
        .o_alighted      (o_alighted),
        .o_boarded       (o_boarded)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- car model ----------------
    function automatic void car_clear(inout t_car c);
        for (int i = 0; i < SLOTS; i++) begin
            c.used[i] = 0;
            c.ph[i]   = PH_WAIT;
            c.cl[i]   = 0;
            c.tg[i]   = 0;
        end
        c.flr     = 0;
        c.gl      = 0;
        c.hd      = MO_STOP;
        c.ret_leg = 0;
        c.run     = 0;
    endfunction

    function automatic void retarget(inout t_car c);
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        bit any;
        lo  = 'hFFFF;
        hi  = 0;
        any = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (c.used[i]) begin
                v = c.ret_leg ? c.tg[i] : c.cl[i];
                if (v < lo) lo = v;
                if (v > hi) hi = v;
                any = 1;
            end
        end
        if (any) begin
            if (c.flr == hi && c.gl == lo) c.gl = c.flr;
            else c.gl = (c.flr < hi) ? hi : lo;
        end
    endfunction

    function automatic void open_doors(inout t_car c);
        bit boarded;
        boarded = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (c.used[i] && c.ph[i] == PH_CAR && c.tg[i] == c.flr) begin
                c.ph[i] = PH_DONE;
                if (c.n_off < 31) c.n_off++;
                c.door = 1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (c.used[i] && c.ph[i] == PH_WAIT && c.cl[i] == c.flr) begin
                c.ph[i] = PH_CAR;
                if (c.n_on < 31) c.n_on++;
                c.door  = 1;
                boarded = 1;
            end
        end
        if (boarded) retarget(c);
    endfunction

    function automatic void head_out(inout t_car c);
        c.hd = (c.flr < c.gl) ? MO_UP : MO_DOWN;
    endfunction

    function automatic void park(inout t_car c);
        for (int i = 0; i < SLOTS; i++) c.used[i] = 0;
        c.hd      = MO_STOP;
        c.ret_leg = 0;
        c.run     = 0;
    endfunction

    function automatic void sweep_done(inout t_car c);
        if (c.ret_leg) begin
            park(c);
        end else begin
            c.ret_leg = 1;
            retarget(c);
            if (c.flr == c.gl) begin
                open_doors(c);
                park(c);
            end else begin
                head_out(c);
            end
        end
    endfunction

    function automatic t_trip car_step(inout t_car c, input t_item it);
        t_trip r;
        int unsigned cf;
        int unsigned tf;
        int free_idx;
        t_motion want;
        r.status = ST_OK;
        c.n_off  = 0;
        c.n_on   = 0;
        c.door   = 0;
        cf = (it.call > FLOORS - 1) ? FLOORS - 1 : it.call;
        tf = (it.target > FLOORS - 1) ? FLOORS - 1 : it.target;
        if (it.is_add) begin
            free_idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--) if (!c.used[i]) free_idx = i;
            want = (tf > cf) ? MO_UP : MO_DOWN;
            if (c.run && c.hd != want) begin
                r.status = ST_DIR;
            end else if (free_idx < 0) begin
                r.status = ST_FULL;
            end else begin
                c.used[free_idx] = 1;
                c.ph[free_idx]   = PH_WAIT;
                c.cl[free_idx]   = cf;
                c.tg[free_idx]   = tf;
                if (!c.run) begin
                    c.run     = 1;
                    c.ret_leg = 0;
                    c.gl      = cf;
                    retarget(c);
                    if (c.flr == c.gl) begin
                        open_doors(c);
                        sweep_done(c);
                    end else begin
                        head_out(c);
                    end
                end
            end
        end else if (c.run && c.hd != MO_STOP) begin
            if (c.hd == MO_UP && c.flr < c.gl) c.flr++;
            else if (c.hd == MO_DOWN && c.flr > c.gl) c.flr--;
            open_doors(c);
            if ((c.hd == MO_UP && c.flr >= c.gl) || (c.hd == MO_DOWN && c.flr <= c.gl))
                sweep_done(c);
        end
        r.car_floor  = c.flr[FLOOR_W-1:0];
        r.goal_floor = c.gl[FLOOR_W-1:0];
        r.motion     = c.hd;
        r.ret_leg    = c.ret_leg;
        r.run        = c.run;
        r.door       = c.door;
        r.off_cnt    = c.n_off[CNT_W-1:0];
        r.on_cnt     = c.n_on[CNT_W-1:0];
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic void queue_item(bit is_add, int cf, int tf, bit no_gap, bit drain);
        t_item it;
        t_trip unused;
        it.is_add = is_add;
        it.call   = FLOOR_W'(cf);
        it.target = FLOOR_W'(tf);
        it.gap    = no_gap ? 0 : $urandom_range(0, 11);
        it.drain  = drain;
        unused    = car_step(plan_car, it);
        pending_q.push_back(it);
    endfunction

    initial begin : stim
        bit calm;
        int a;
        int b;
        int lo;
        int hi;
        start          = 1'b0;
        i_req_type     = 1'b0;
        i_call_floor   = '0;
        i_target_floor = '0;
        i_rst_n        = 1'b0;
        i_clk          = 1'b0;
        car_clear(plan_car);
        car_clear(live_car);

        queue_item(0, 0, 0, 0, 0);          // tick while parked
        queue_item(1, 0, 0, 0, 0);          // call at the car, target here too
        queue_item(1, 63, 0, 0, 0);         // top floor call, car heads up
        queue_item(1, 5, 2, 0, 0);          // down rider while going up
        queue_item(1, 0, 63, 0, 0);
        for (int i = 0; i < 15; i++) begin  // last one finds the table full
            a = $urandom_range(0, 62);
            queue_item(1, a, $urandom_range(a + 1, 63), 0, 0);
        end
        queue_item(0, 0, 0, 0, 1);

        calm = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) calm = ($urandom_range(0, 9) < 3);
            if (!plan_car.run) begin
                if ($urandom_range(0, 9) < 8)
                    queue_item(1, $urandom, $urandom, calm, n == 500);
                else
                    queue_item(0, $urandom, $urandom, calm, n == 500);
            end else if ($urandom_range(0, 9) < 6) begin
                queue_item(0, $urandom, $urandom, calm, n == 500);
            end else if ($urandom_range(0, 9) < 8) begin
                a  = $urandom_range(0, 63);
                b  = $urandom_range(0, 63);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                if (plan_car.hd == MO_UP) begin
                    if (lo == hi) hi = (lo == 63) ? 63 : lo + 1;
                    if (lo == hi) lo = 62;
                    queue_item(1, lo, hi, calm, n == 500);
                end else begin
                    queue_item(1, hi, lo, calm, n == 500);
                end
            end else begin
                queue_item(1, $urandom, $urandom, calm, n == 500);
            end
        end
        n_total = pending_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_total && trip_q.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("Covered %0d items: %0d ticks, %0d adds, %0d wrong-direction and %0d full-table",
                 n_sent, n_ticks, n_adds, n_dir_rej, n_full_rej);
        $display("rejects, %0d runs parked, %0d results checked", n_runs, n_checked);
        if (n_bad == 0 && trip_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin : drive
        bit    nxt_start;
        int    nxt_wait;
        bit    was_run;
        t_item cur;
        t_trip res;
        nxt_start = start;
        nxt_wait  = wait_cnt;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_wait  = 0;
        end else begin
            if (start && !busy) begin
                cur.is_add = i_req_type;
                cur.call   = i_call_floor;
                cur.target = i_target_floor;
                was_run    = live_car.run;
                res = car_step(live_car, cur);
                trip_q.push_back(res);
                n_sent++;
                if (!cur.is_add) n_ticks++;
                else n_adds++;
                if (res.status == ST_DIR) n_dir_rej++;
                if (res.status == ST_FULL) n_full_rej++;
                if (res.status == ST_OK && !res.run && (was_run || cur.is_add)) n_runs++;
                nxt_start = 1'b0;
                nxt_wait  = 0;
            end
            if (!nxt_start && pending_q.size() > 0) begin
                if (pending_q[0].drain && !(trip_q.size() == 0 && !o_valid)) begin
                    nxt_wait = 0;
                end else if (nxt_wait >= pending_q[0].gap) begin
                    cur = pending_q.pop_front();
                    i_req_type     <= cur.is_add;
                    i_call_floor   <= cur.call;
                    i_target_floor <= cur.target;
                    nxt_start = 1'b1;
                    nxt_wait  = 0;
                end else begin
                    nxt_wait++;
                end
            end
        end
        start    <= nxt_start;
        wait_cnt <= nxt_wait;
    end

    // ---------------- monitor ----------------
    task automatic check_field(string nm, int exp_v, int act_v);
        if (exp_v != act_v) begin
            n_bad++;
            if (n_bad <= 10)
                $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                         n_checked, nm, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_trip e;
        if (i_rst_n && o_valid) begin
            if (trip_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("Result transfer with nothing expected");
            end else begin
                e = trip_q.pop_front();
                check_field("status",        e.status,     o_status);
                check_field("car_floor",     e.car_floor,  o_car_floor);
                check_field("goal_floor",    e.goal_floor, o_goal_floor);
                check_field("motion",        e.motion,     o_motion);
                check_field("on_return_leg", e.ret_leg,    o_on_return_leg);
                check_field("run_active",    e.run,        o_run_active);
                check_field("door_cycled",   e.door,       o_door_cycled);
                check_field("alighted",      e.off_cnt,    o_alighted);
                check_field("boarded",       e.on_cnt,     o_boarded);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cycles     = 0;
        wait_cnt   = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_bad      = 0;
        n_ticks    = 0;
        n_adds     = 0;
        n_dir_rej  = 0;
        n_full_rej = 0;
        n_runs     = 0;
    end
endmodule
